// ----- rtl/jic_pkg.sv -----
// ----------------------------------------------------------------------------
// jic_pkg
// Shared constants, gain tables, state and beat types of the joint impedance
// controller.
// ----------------------------------------------------------------------------
package jic_pkg;

    localparam int NUM_JOINTS         = 7;
    // power of two
    localparam int SINE_TABLE_ENTRIES = 256;
    localparam int SINE_BITS          = $clog2(SINE_TABLE_ENTRIES);
    localparam int JIDX_W             = (NUM_JOINTS > 1) ? $clog2(NUM_JOINTS) : 1;

    localparam logic [2:0]  JOINT_LAST = 3'(NUM_JOINTS - 1);
    localparam logic [31:0] PHASE_MASK = ~((32'd1 << (32 - SINE_BITS)) - 32'd1);

    // serial multiplier geometry
    localparam int MUL_A_W   = 27;
    localparam int MUL_B_W   = 17;
    localparam int MUL_P_W   = MUL_A_W + MUL_B_W;
    localparam int MUL_CNT_W = $clog2(MUL_B_W + 1);

    // per-joint gains, N*m/rad and N*m*s/rad
    localparam logic [MUL_B_W-1:0] GAIN_P [8] = '{
        17'd3000, 17'd3000, 17'd800, 17'd800, 17'd200, 17'd200, 17'd200, 17'd200
    };
    localparam logic [MUL_B_W-1:0] GAIN_D [8] = '{
        17'd80, 17'd80, 17'd40, 17'd40, 17'd8, 17'd8, 17'd8, 17'd8
    };

    // sine polynomial, Q16
    localparam logic [16:0] SIN_ONE = 17'd65536;
    localparam logic [16:0] SIN_C1  = 17'd4640;
    localparam logic [16:0] SIN_C2  = 17'd42047;
    localparam logic [16:0] SIN_C3  = 17'd102944;
    localparam logic [MUL_P_W-1:0] ROUND_HALF = MUL_P_W'(32768);

    // register reset values: 0.035 rad, 0.3 Hz at 1 ms
    localparam logic        MODE_RST = 1'b0;
    localparam logic [15:0] AMP_RST  = 16'd2294;
    localparam logic [31:0] STEP_RST = 32'd1288490;

    typedef enum logic [1:0] {
        CFG_MODE = 2'd0,
        CFG_AMP  = 2'd1,
        CFG_STEP = 2'd2
    } t_cfg_idx;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_T2,
        ST_U,
        ST_W,
        ST_S,
        ST_D,
        ST_ERR,
        ST_KP,
        ST_KD,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic [2:0]  joint;
        logic        last;
        logic [23:0] pos;
        logic [23:0] vel;
        logic [23:0] hold;
        logic        mode;
        logic [15:0] amp;
        logic [31:0] phase;
    } t_job;

    typedef struct packed {
        logic [2:0]  joint;
        logic [31:0] torque;
        logic        last;
    } t_res;

    typedef struct packed {
        logic               start;
        logic [MUL_A_W-1:0] a;
        logic [MUL_B_W-1:0] b;
    } t_mul_req;

    typedef struct packed {
        logic               done;
        logic [MUL_P_W-1:0] prod;
    } t_mul_rsp;

endpackage

// ----- rtl/joint_impedance_controller.sv -----
// ----------------------------------------------------------------------------
// joint_impedance_controller
// Per-joint PD impedance controller with optional sine-sweep reference.
// ----------------------------------------------------------------------------
// Input beats carry one joint sample (joint, position, velocity); a control
// tick ends with the beat for the last joint. The first tick after reset
// captures the positions as hold targets and gives no output beats. Later
// beats each give one torque beat (joint_out, torque, last). Beats with a
// joint index beyond the last joint are dropped.
// Every product of a torque beat runs in turn on one bit-serial multiplier
// (two products in hold mode, seven in sweep mode). The next input beat is
// accepted once the sequencer is idle again; capture and dropped beats do
// not start the sequencer. One output register lets the next beat be worked
// on while a torque beat waits under i_out_stall; a further result then
// holds the sequencer and o_in_stall stays high.
// Reset clears the capture flag and phase and loads the register defaults.
// The user must write registers through the cfg port only while no beat is
// in flight; the block itself does not enforce this.
// ----------------------------------------------------------------------------
module joint_impedance_controller (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [2:0]  i_joint,
    input  logic [23:0] i_position,
    input  logic [23:0] i_velocity,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [2:0]  o_joint_out,
    output logic [31:0] o_torque,
    output logic        o_last,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data
);

    logic        r_mode;
    logic [15:0] r_amp;
    logic [31:0] r_step;
    logic [31:0] r_phase;
    logic        r_captured;
    logic        r_out_valid;
    jic_pkg::t_res r_out;
    logic [23:0] r_hold [jic_pkg::NUM_JOINTS];

    logic                       in_accept;
    logic                       out_accept;
    logic                       cfg_we;
    logic                       joint_ok;
    logic                       joint_last;
    logic [jic_pkg::JIDX_W-1:0] idx;
    logic                       core_start;
    logic                       core_idle;
    logic                       core_res_valid;
    logic                       res_take;
    jic_pkg::t_job              job;
    jic_pkg::t_res              core_res;

    assign o_in_stall  = !core_idle;
    assign o_cfg_ready = 1'b1;
    assign in_accept   = i_in_valid && !o_in_stall;
    assign out_accept  = r_out_valid && !i_out_stall;
    assign cfg_we      = i_cfg_valid && o_cfg_ready;
    assign joint_ok    = ({29'd0, i_joint} < 32'(jic_pkg::NUM_JOINTS));
    assign joint_last  = (i_joint == jic_pkg::JOINT_LAST);
    assign idx         = jic_pkg::JIDX_W'(i_joint);
    assign core_start  = in_accept && joint_ok && r_captured;
    assign res_take    = core_res_valid && (!r_out_valid || out_accept);

    always_comb begin
        job.joint = i_joint;
        job.last  = joint_last;
        job.pos   = i_position;
        job.vel   = i_velocity;
        job.hold  = r_hold[idx];
        job.mode  = r_mode;
        job.amp   = r_amp;
        job.phase = r_phase;
    end

    jic_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (core_start),
        .i_job       (job),
        .o_idle      (core_idle),
        .o_res_valid (core_res_valid),
        .o_res       (core_res),
        .i_res_take  (res_take)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= jic_pkg::MODE_RST;
            r_amp       <= jic_pkg::AMP_RST;
            r_step      <= jic_pkg::STEP_RST;
            r_phase     <= '0;
            r_captured  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_accept && joint_ok && joint_last) begin
                r_phase <= r_phase + r_step;
                r_captured <= 1'b1;
            end
            if (cfg_we) begin
                case (jic_pkg::t_cfg_idx'(i_cfg_index))
                    jic_pkg::CFG_MODE: r_mode <= i_cfg_data[0];
                    jic_pkg::CFG_AMP:  r_amp  <= i_cfg_data[15:0];
                    jic_pkg::CFG_STEP: r_step <= i_cfg_data;
                    default: ;
                endcase
            end
            if (res_take) begin
                r_out_valid <= 1'b1;
            end else if (out_accept) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept && joint_ok && !r_captured) begin
            r_hold[idx] <= i_position;
        end
        if (res_take) begin
            r_out <= core_res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_joint_out = r_out.joint;
    assign o_torque    = r_out.torque;
    assign o_last      = r_out.last;

    a_take_fills: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        res_take |=> r_out_valid)
        else $error("result taken but output register empty");

    a_captured_sticks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_captured |=> r_captured)
        else $error("capture flag cleared outside reset");

    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        core_start |=> !core_idle)
        else $error("sequencer did not start on a tracking beat");

    a_out_after_capture: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> r_captured)
        else $error("torque beat before capture tick completed");

endmodule

// ----- rtl/jic_smul.sv -----
// ----------------------------------------------------------------------------
// jic_smul
// Bit-serial shift-add multiplier: signed multiplicand, unsigned multiplier,
// one multiplier bit per cycle.
// ----------------------------------------------------------------------------
module jic_smul (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  jic_pkg::t_mul_req  i_req,
    output jic_pkg::t_mul_rsp  o_rsp
);

    logic                          r_busy;
    logic                          r_done;
    logic [jic_pkg::MUL_CNT_W-1:0] r_cnt;
    logic [jic_pkg::MUL_A_W-1:0]   r_a;
    logic [jic_pkg::MUL_A_W:0]     r_hi;
    logic [jic_pkg::MUL_B_W-1:0]   r_lo;

    logic [jic_pkg::MUL_A_W:0]     addend;
    logic [jic_pkg::MUL_A_W+1:0]   sum;
    logic [jic_pkg::MUL_A_W:0]     n_hi;
    logic [jic_pkg::MUL_B_W-1:0]   n_lo;

    always_comb begin
        addend = r_lo[0] ? {r_a[jic_pkg::MUL_A_W-1], r_a} : '0;
        sum    = {r_hi[jic_pkg::MUL_A_W], r_hi} + {addend[jic_pkg::MUL_A_W], addend};
        n_hi   = sum[jic_pkg::MUL_A_W+1:1];
        n_lo   = {sum[0], r_lo[jic_pkg::MUL_B_W-1:1]};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= jic_pkg::MUL_CNT_W'(jic_pkg::MUL_B_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == jic_pkg::MUL_CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_a  <= i_req.a;
            r_hi <= '0;
            r_lo <= i_req.b;
        end else if (r_busy) begin
            r_hi <= n_hi;
            r_lo <= n_lo;
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.prod = {r_hi[jic_pkg::MUL_A_W-1:0], r_lo};

endmodule

// ----- rtl/jic_core.sv -----
// ----------------------------------------------------------------------------
// jic_core
// Torque sequencer: sine offset in sweep mode, position error and PD law, all products
// taken in turn on one serial multiplier.
// ----------------------------------------------------------------------------
module jic_core (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  jic_pkg::t_job i_job,
    output logic          o_idle,
    output logic          o_res_valid,
    output jic_pkg::t_res o_res,
    input  logic          i_res_take
);

    jic_pkg::t_state   r_state;
    jic_pkg::t_state   n_state;
    logic              r_mstart;
    logic              n_mstart;

    jic_pkg::t_job     r_job;
    logic [1:0]        r_q;
    logic [16:0]       r_t;
    logic [16:0]       r_t2;
    logic [16:0]       r_opb;
    logic [17:0]       r_off;
    logic [jic_pkg::MUL_A_W-1:0] r_err;
    logic [jic_pkg::MUL_P_W-1:0] r_kp;
    logic [31:0]       r_torque;

    jic_pkg::t_mul_req mul_req;
    jic_pkg::t_mul_rsp mul_rsp;

    logic [31:0]       p;
    logic [16:0]       t_raw;
    logic [17:0]       s_full;
    logic [jic_pkg::MUL_P_W-1:0] rnd;
    logic [17:0]       d_ext;
    logic [jic_pkg::MUL_P_W:0]   diff;

    jic_smul u_smul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (mul_req),
        .o_rsp   (mul_rsp)
    );

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            jic_pkg::ST_IDLE: begin
                if (i_start) begin
                    n_state = i_job.mode ? jic_pkg::ST_T2 : jic_pkg::ST_ERR;
                end
            end
            jic_pkg::ST_T2:   if (mul_rsp.done) n_state = jic_pkg::ST_U;
            jic_pkg::ST_U:    if (mul_rsp.done) n_state = jic_pkg::ST_W;
            jic_pkg::ST_W:    if (mul_rsp.done) n_state = jic_pkg::ST_S;
            jic_pkg::ST_S:    if (mul_rsp.done) n_state = jic_pkg::ST_D;
            jic_pkg::ST_D:    if (mul_rsp.done) n_state = jic_pkg::ST_ERR;
            jic_pkg::ST_ERR:  n_state = jic_pkg::ST_KP;
            jic_pkg::ST_KP:   if (mul_rsp.done) n_state = jic_pkg::ST_KD;
            jic_pkg::ST_KD:   if (mul_rsp.done) n_state = jic_pkg::ST_DONE;
            jic_pkg::ST_DONE: if (i_res_take) n_state = jic_pkg::ST_IDLE;
            default:          n_state = jic_pkg::ST_IDLE;
        endcase
        n_mstart = (n_state != r_state) && (n_state != jic_pkg::ST_IDLE) &&
                   (n_state != jic_pkg::ST_ERR) && (n_state != jic_pkg::ST_DONE);
    end

    // outputs and multiplier operands
    always_comb begin
        o_idle      = (r_state == jic_pkg::ST_IDLE);
        o_res_valid = (r_state == jic_pkg::ST_DONE);
        mul_req.start = r_mstart;
        mul_req.a     = '0;
        mul_req.b     = '0;
        case (r_state)
            jic_pkg::ST_T2: begin
                mul_req.a = jic_pkg::MUL_A_W'(r_t);
                mul_req.b = r_t;
            end
            jic_pkg::ST_U: begin
                mul_req.a = jic_pkg::MUL_A_W'(r_t2);
                mul_req.b = jic_pkg::SIN_C1;
            end
            jic_pkg::ST_W: begin
                mul_req.a = jic_pkg::MUL_A_W'(r_t2);
                mul_req.b = r_opb;
            end
            jic_pkg::ST_S: begin
                mul_req.a = jic_pkg::MUL_A_W'(r_t);
                mul_req.b = r_opb;
            end
            jic_pkg::ST_D: begin
                mul_req.a = jic_pkg::MUL_A_W'(r_job.amp);
                mul_req.b = r_opb;
            end
            jic_pkg::ST_KP: begin
                mul_req.a = r_err;
                mul_req.b = jic_pkg::GAIN_P[r_job.joint];
            end
            jic_pkg::ST_KD: begin
                mul_req.a = {{(jic_pkg::MUL_A_W-24){r_job.vel[23]}}, r_job.vel};
                mul_req.b = jic_pkg::GAIN_D[r_job.joint];
            end
            default: begin
                mul_req.a = '0;
                mul_req.b = '0;
            end
        endcase
    end

    always_comb begin
        p      = i_job.phase & jic_pkg::PHASE_MASK;
        t_raw  = {1'b0, p[29:14]};
        s_full = mul_rsp.prod[33:16];
        rnd    = mul_rsp.prod + jic_pkg::ROUND_HALF;
        d_ext  = {2'b00, rnd[31:16]};
        diff   = {r_kp[jic_pkg::MUL_P_W-1], r_kp} -
                 {mul_rsp.prod[jic_pkg::MUL_P_W-1], mul_rsp.prod};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= jic_pkg::ST_IDLE;
            r_mstart <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_mstart <= n_mstart;
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            jic_pkg::ST_IDLE: begin
                if (i_start) begin
                    r_job <= i_job;
                    r_q   <= p[31:30];
                    r_t   <= p[30] ? (jic_pkg::SIN_ONE - t_raw) : t_raw;
                    r_off <= '0;
                end
            end
            jic_pkg::ST_T2: if (mul_rsp.done) r_t2 <= mul_rsp.prod[32:16];
            jic_pkg::ST_U:  if (mul_rsp.done) r_opb <= jic_pkg::SIN_C2 - mul_rsp.prod[32:16];
            jic_pkg::ST_W:  if (mul_rsp.done) r_opb <= jic_pkg::SIN_C3 - mul_rsp.prod[32:16];
            jic_pkg::ST_S: begin
                if (mul_rsp.done) begin
                    r_opb <= (s_full > {1'b0, jic_pkg::SIN_ONE}) ? jic_pkg::SIN_ONE
                                                                 : s_full[16:0];
                end
            end
            jic_pkg::ST_D:  if (mul_rsp.done) r_off <= r_q[1] ? (18'd0 - d_ext) : d_ext;
            jic_pkg::ST_ERR: begin
                r_err <= {{(jic_pkg::MUL_A_W-24){r_job.hold[23]}}, r_job.hold} +
                         {{(jic_pkg::MUL_A_W-18){r_off[17]}}, r_off} -
                         {{(jic_pkg::MUL_A_W-24){r_job.pos[23]}}, r_job.pos};
            end
            jic_pkg::ST_KP: if (mul_rsp.done) r_kp <= mul_rsp.prod;
            jic_pkg::ST_KD: begin
                if (mul_rsp.done) begin
                    if (!diff[jic_pkg::MUL_P_W] && (diff[jic_pkg::MUL_P_W-1:31] != '0)) begin
                        r_torque <= 32'h7FFF_FFFF;
                    end else if (diff[jic_pkg::MUL_P_W] &&
                                 (diff[jic_pkg::MUL_P_W-1:31] != '1)) begin
                        r_torque <= 32'h8000_0000;
                    end else begin
                        r_torque <= diff[31:0];
                    end
                end
            end
            default: ;
        endcase
    end

    assign o_res.joint  = r_job.joint;
    assign o_res.torque = r_torque;
    assign o_res.last   = r_job.last;

endmodule

// ----- tb/jic_checker.sv -----
// ----------------------------------------------------------------------------
// jic_checker
// Watches the sample, torque and register channels of the joint impedance
// controller. It keeps its own copy of the hold targets, capture flag, phase
// and registers, works out the torque beat due for each accepted joint
// sample after the capture tick, and compares every torque beat in order, field by field.
// ----------------------------------------------------------------------------
module jic_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_stall,
    input  logic [2:0]  i_joint,
    input  logic [23:0] i_position,
    input  logic [23:0] i_velocity,
    input  logic        i_out_valid,
    input  logic        i_out_stall,
    input  logic [2:0]  i_joint_out,
    input  logic [31:0] i_torque,
    input  logic        i_last,
    input  logic        i_cfg_valid,
    input  logic        i_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data,
    output int          o_errors,
    output int          o_pending,
    output int          o_checked
);

    localparam int          JOINTS     = 7;
    localparam logic [2:0]  LAST_JOINT = 3'd6;
    localparam logic [63:0] TABLE_SIZE = 64'd256;
    localparam longint      TORQUE_MAX = 64'sd2147483647;
    localparam longint      TORQUE_MIN = -64'sd2147483648;

    typedef struct packed {
        logic [2:0]  joint;
        logic [31:0] torque;
        logic        last;
    } t_torque_beat;

    t_torque_beat       torque_due [$];
    logic signed [23:0] hold_pos [JOINTS];
    logic               captured;
    logic [31:0]        phase_acc;
    logic               sweep_on;
    logic [15:0]        sweep_amp;
    logic [31:0]        phase_inc;
    int                 fail_count = 0;
    int                 beat_count = 0;

    // sine of the table-quantised phase scaled by the amplitude, rounded
    function automatic longint sweep_offset(input logic [31:0] ph, input logic [15:0] amp);
        logic [63:0] k, t, t2, u, w, s, d;
        logic [31:0] p;
        logic [1:0]  quad;
        k    = ({32'd0, ph} * TABLE_SIZE) >> 32;
        p    = 32'((k << 32) / TABLE_SIZE);
        quad = p[31:30];
        t    = 64'(p[29:14]);
        if (quad[0]) begin
            t = 64'd65536 - t;
        end
        t2 = (t * t) >> 16;
        u  = (64'd4640 * t2) >> 16;
        w  = ((64'd42047 - u) * t2) >> 16;
        s  = (t * (64'd102944 - w)) >> 16;
        if (s > 64'd65536) begin
            s = 64'd65536;
        end
        d = (64'(amp) * s + 64'd32768) >> 16;
        return quad[1] ? -longint'(d) : longint'(d);
    endfunction

    function automatic t_torque_beat predict_torque(
        input logic [2:0]         j,
        input logic signed [23:0] pos,
        input logic signed [23:0] vel,
        input logic signed [23:0] hold,
        input logic               sweep,
        input logic [15:0]        amp,
        input logic [31:0]        ph
    );
        longint       kp, kd, target, trq;
        t_torque_beat beat;
        case (j)
            3'd0, 3'd1: begin
                kp = 3000;
                kd = 80;
            end
            3'd2, 3'd3: begin
                kp = 800;
                kd = 40;
            end
            default: begin
                kp = 200;
                kd = 8;
            end
        endcase
        target = longint'(hold);
        if (sweep) begin
            target = target + sweep_offset(ph, amp);
        end
        trq = kp * (target - longint'(pos)) - kd * longint'(vel);
        if (trq > TORQUE_MAX) begin
            trq = TORQUE_MAX;
        end
        if (trq < TORQUE_MIN) begin
            trq = TORQUE_MIN;
        end
        beat.joint  = j;
        beat.torque = trq[31:0];
        beat.last   = (j == LAST_JOINT);
        return beat;
    endfunction

    always @(posedge i_clk) begin : watch
        t_torque_beat want;
        if (!i_rst_n) begin
            torque_due.delete();
            captured  = 1'b0;
            phase_acc = 32'd0;
            sweep_on  = 1'b0;
            sweep_amp = 16'd2294;
            phase_inc = 32'd1288490;
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                if (i_cfg_index == jic_pkg::CFG_MODE) begin
                    sweep_on = i_cfg_data[0];
                end else if (i_cfg_index == jic_pkg::CFG_AMP) begin
                    sweep_amp = i_cfg_data[15:0];
                end else if (i_cfg_index == jic_pkg::CFG_STEP) begin
                    phase_inc = i_cfg_data;
                end
            end

            if (i_out_valid && !i_out_stall) begin
                if (torque_due.size() == 0) begin
                    fail_count = fail_count + 1;
                    if (fail_count <= 10) begin
                        $display("unexpected torque beat: joint %0d torque %0d last %0d",
                                 i_joint_out, $signed(i_torque), i_last);
                    end
                end else begin
                    want = torque_due.pop_front();
                    beat_count = beat_count + 1;
                    if (i_joint_out !== want.joint || i_torque !== want.torque ||
                        i_last !== want.last) begin
                        fail_count = fail_count + 1;
                        if (fail_count <= 10) begin
                            $display("torque beat mismatch: exp joint %0d torque %0d last %0d,",
                                     want.joint, $signed(want.torque), want.last,
                                     " got joint %0d torque %0d last %0d",
                                     i_joint_out, $signed(i_torque), i_last);
                        end
                    end
                end
            end

            if (i_in_valid && !i_in_stall && i_joint < 3'(JOINTS)) begin
                if (!captured) begin
                    hold_pos[i_joint] = i_position;
                end else begin
                    torque_due.push_back(predict_torque(i_joint, i_position, i_velocity,
                                                        hold_pos[i_joint], sweep_on,
                                                        sweep_amp, phase_acc));
                end
                if (i_joint == LAST_JOINT) begin
                    captured  = 1'b1;
                    phase_acc = phase_acc + phase_inc;
                end
            end
        end
        o_errors  <= fail_count;
        o_pending <= torque_due.size();
        o_checked <= beat_count;
    end

endmodule

// ----- tb/joint_impedance_controller_tb.sv -----
// ----------------------------------------------------------------------------
// joint_impedance_controller_tb
// Drives joint samples and register writes into the joint impedance
// controller under bursty input and patterned output stalls; a separate
// checker predicts and compares the torque beats.
// ----------------------------------------------------------------------------
module joint_impedance_controller_tb;

    localparam int CYCLE_LIMIT = 2000000;
    localparam int SETTLE      = 200;

    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        i_in_valid  = 1'b0;
    logic [2:0]  i_joint     = 3'd0;
    logic [23:0] i_position  = 24'd0;
    logic [23:0] i_velocity  = 24'd0;
    logic        i_out_stall = 1'b0;
    logic        i_cfg_valid = 1'b0;
    logic [1:0]  i_cfg_index = 2'd0;
    logic [31:0] i_cfg_data  = 32'd0;
    logic        o_in_stall;
    logic        o_out_valid;
    logic [2:0]  o_joint_out;
    logic [31:0] o_torque;
    logic        o_last;
    logic        o_cfg_ready;

    int          errors;
    int          pending;
    int          checked;
    int          samples    = 0;
    int          dropped    = 0;
    int          cfg_writes = 0;
    int          settings   = 0;
    int          burst_left = 0;
    int          cycles     = 0;
    int          stall_left = 0;
    logic [31:0] rx_cycle   = 32'd0;
    logic [23:0] hold_ref [7];

    always #2 i_clk = ~i_clk;

    joint_impedance_controller dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_joint     (i_joint),
        .i_position  (i_position),
        .i_velocity  (i_velocity),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_joint_out (o_joint_out),
        .o_torque    (o_torque),
        .o_last      (o_last),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    jic_checker torque_check (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_stall  (o_in_stall),
        .i_joint     (i_joint),
        .i_position  (i_position),
        .i_velocity  (i_velocity),
        .i_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_joint_out (o_joint_out),
        .i_torque    (o_torque),
        .i_last      (o_last),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_errors    (errors),
        .o_pending   (pending),
        .o_checked   (checked)
    );

    // receiver stall pattern, its character chosen by rx_cycle bits 10:9
    always @(posedge i_clk) begin
        rx_cycle = rx_cycle + 32'd1;
        case (rx_cycle[10:9])
            2'd0: begin
                i_out_stall <= 1'b0;
            end
            2'd1: begin
                i_out_stall <= ($urandom_range(0, 1) == 0);
            end
            2'd2: begin
                if (stall_left == 0 && $urandom_range(0, 15) == 0) begin
                    stall_left = $urandom_range(1, 40);
                end
                if (stall_left != 0) begin
                    stall_left = stall_left - 1;
                    i_out_stall <= 1'b1;
                end else begin
                    i_out_stall <= 1'b0;
                end
            end
            default: begin
                i_out_stall <= rx_cycle[1];
            end
        endcase
    end

    always @(posedge i_clk) begin
        cycles = cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d torque beats outstanding", cycles, pending);
            $display("FAILED: results differ");
            $finish;
        end
    end

    function automatic logic [23:0] pick_position(input logic [23:0] centre);
        case ($urandom_range(0, 7))
            0:       return 24'h7FFFFF;
            1:       return 24'h800000;
            2, 3:    return 24'($urandom());
            default: return centre + 24'($urandom_range(0, 8191)) - 24'd4096;
        endcase
    endfunction

    function automatic logic [23:0] pick_velocity();
        case ($urandom_range(0, 7))
            0:       return 24'h7FFFFF;
            1:       return 24'h800000;
            2, 3:    return 24'($urandom());
            default: return 24'($urandom_range(0, 8191)) - 24'd4096;
        endcase
    endfunction

    task automatic send_sample(input logic [2:0] j, input logic [23:0] p, input logic [23:0] v);
        i_in_valid <= 1'b1;
        i_joint    <= j;
        i_position <= p;
        i_velocity <= v;
        @(posedge i_clk);
        while (o_in_stall) begin
            @(posedge i_clk);
        end
        if (j < 3'd7) begin
            samples = samples + 1;
        end else begin
            dropped = dropped + 1;
        end
        if (burst_left > 0) begin
            burst_left = burst_left - 1;
        end else begin
            i_in_valid <= 1'b0;
            if ($urandom_range(0, 3) == 0) begin
                repeat ($urandom_range(20, 150)) @(posedge i_clk);
            end else begin
                repeat ($urandom_range(1, 12)) @(posedge i_clk);
            end
            burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(20, 40) :
                                                        $urandom_range(0, 8);
        end
    endtask

    task automatic cfg_write(input jic_pkg::t_cfg_idx idx, input logic [31:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) begin
            @(posedge i_clk);
        end
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
        cfg_writes = cfg_writes + 1;
    endtask

    // drain all torque beats, then let any capture or dropped beat finish
    task automatic settle();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic apply_setting(input logic mode, input logic [15:0] amp,
                                 input logic [31:0] step);
        settle();
        cfg_write(jic_pkg::CFG_MODE, {31'd0, mode});
        cfg_write(jic_pkg::CFG_AMP, {16'd0, amp});
        cfg_write(jic_pkg::CFG_STEP, step);
        settings = settings + 1;
    endtask

    task automatic send_tick();
        for (int j = 0; j < 7; j++) begin
            if ($urandom_range(0, 11) == 0) begin
                send_sample(3'd7, 24'($urandom()), 24'($urandom()));
            end
            send_sample(3'(j), pick_position(hold_ref[j]), pick_velocity());
        end
    endtask

    // out-of-order joints, repeats, partial ticks and dropped indices
    task automatic send_jumble();
        logic [2:0] j;
        repeat ($urandom_range(1, 10)) begin
            j = 3'($urandom_range(0, 7));
            send_sample(j, pick_position(hold_ref[j % 3'd7]), pick_velocity());
        end
    endtask

    initial begin : stimulus
        int goal;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // capture tick with extreme hold targets and one dropped beat
        apply_setting(1'b0, 16'd2294, 32'd1288490);
        hold_ref[0] = 24'h7FFFFF;
        hold_ref[1] = 24'h800000;
        hold_ref[2] = 24'h000000;
        for (int j = 3; j < 7; j++) begin
            hold_ref[j] = 24'($urandom());
        end
        for (int j = 0; j < 7; j++) begin
            if (j == 3) begin
                send_sample(3'd7, 24'h7FFFFF, 24'h800000);
            end
            send_sample(3'(j), hold_ref[j], pick_velocity());
        end

        // hold mode: both saturation limits, zero error, extreme velocities
        send_sample(3'd0, 24'h800000, 24'h800000);
        send_sample(3'd1, 24'h7FFFFF, 24'h7FFFFF);
        send_sample(3'd2, hold_ref[2], 24'h000000);
        send_sample(3'd7, 24'h000000, 24'h000000);
        send_sample(3'd3, hold_ref[3], 24'h7FFFFF);
        send_sample(3'd4, hold_ref[4], 24'h800000);
        send_sample(3'd5, pick_position(hold_ref[5]), pick_velocity());
        send_sample(3'd6, pick_position(hold_ref[6]), pick_velocity());

        // sweep at full amplitude, quarter turn per tick
        apply_setting(1'b1, 16'hFFFF, 32'h4000_0000);
        for (int j = 0; j < 7; j++) begin
            send_sample(3'(j), hold_ref[j], 24'h000000);
        end

        for (int ph = 0; ph < 8; ph++) begin
            case (ph)
                0: apply_setting(1'b1, 16'hFFFF, 32'hFFFF_FFFF);
                1: apply_setting(1'b1, 16'h0000, 32'h0000_0000);
                2: apply_setting(1'b0, 16'($urandom()), $urandom());
                3: apply_setting(1'b1, 16'd2294, 32'd1288490);
                4: apply_setting(1'b1, 16'hFFFF, 32'h0100_0000);
                5: apply_setting(1'b1, 16'($urandom()), $urandom());
                6: apply_setting(1'b1, 16'($urandom()), 32'h8000_0000);
                default: apply_setting(1'b0, 16'hFFFF, 32'hFFFF_FFFF);
            endcase
            goal = samples + 100;
            while (samples < goal) begin
                if ($urandom_range(0, 4) == 0) begin
                    send_jumble();
                end else begin
                    send_tick();
                end
            end
        end

        settle();
        $display("Covered %0d joint samples and %0d dropped beats; %0d torque beats checked.",
                 samples, dropped, checked);
        $display("Register writes: %0d over %0d settings of mode, amplitude and phase step.",
                 cfg_writes, settings);
        if (errors == 0 && pending == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule
